// File: src/mnb_pkg.sv
`default_nettype none
package mnb_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_FOFS  = 3'd1;
    localparam logic [2:0] REG_PITCH = 3'd2;
    localparam logic [2:0] REG_QOFS  = 3'd3;
    localparam logic [2:0] REG_RATE  = 3'd4;
    localparam logic [2:0] REG_MODE  = 3'd5;

    function automatic logic [31:0] turn_atan(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0: v = 32'h20000000; 5'd1: v = 32'h12E4051D;
                5'd2: v = 32'h09FB385B; 5'd3: v = 32'h051111D4;
                5'd4: v = 32'h028B0D43; 5'd5: v = 32'h0145D7E1;
                5'd6: v = 32'h00A2F61E; 5'd7: v = 32'h00517C55;
                5'd8: v = 32'h0028BE53; 5'd9: v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [47:0] den;
    } t_div_req;
endpackage
`default_nettype wire

// File: src/mnb_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
module mnb_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mnb_pkg::t_div_req     i_req,
    output logic                       o_done,
    output logic [63:0]                o_quot
);
    logic [63:0] r_quot, n_quot;
    logic [48:0] r_rem, n_rem;
    logic [47:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [48:0] w_sh;

    always_comb begin
        n_quot = r_quot; n_rem = r_rem; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_rem[47:0], r_quot[63]};
        if (i_req.start) begin
            n_quot = i_req.num; n_rem = '0; n_cnt = 7'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_quot <= n_quot; r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: src/mnb_cordic.sv
`default_nettype none
// Iterative CORDIC, one rotation per cycle, with quadrant fold and clamp.
module mnb_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_phase,
    output logic                    o_done,
    output logic signed [33:0]      o_sin,
    output logic signed [33:0]      o_cos
);
    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip, r_busy, r_done;
    logic [4:0]         r_i;
    logic signed [33:0] w_z0, w_xs, w_ys, w_at, w_xf, w_yf;
    logic               w_fl;

    always_comb begin
        w_z0 = {{2{i_phase[31]}}, i_phase};
        w_fl = 1'b0;
        if (w_z0 > 34'sd1073741824) begin
            w_z0 = w_z0 - 34'sd2147483648; w_fl = 1'b1;
        end else if (w_z0 < -34'sd1073741824) begin
            w_z0 = w_z0 + 34'sd2147483648; w_fl = 1'b1;
        end
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_at = {2'b00, mnb_pkg::turn_atan(r_i)};
        w_xf = r_flip ? -r_x : r_x;
        w_yf = r_flip ? -r_y : r_y;
        if (w_xf > mnb_pkg::ONE_Q30) w_xf = mnb_pkg::ONE_Q30;
        if (w_xf < -mnb_pkg::ONE_Q30) w_xf = -mnb_pkg::ONE_Q30;
        if (w_yf > mnb_pkg::ONE_Q30) w_yf = mnb_pkg::ONE_Q30;
        if (w_yf < -mnb_pkg::ONE_Q30) w_yf = -mnb_pkg::ONE_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_i <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_i <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == 5'(mnb_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_x <= mnb_pkg::CORDIC_K; r_y <= '0; r_z <= w_z0; r_flip <= w_fl;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_ys; r_y <= r_y + w_xs; r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys; r_y <= r_y - w_xs; r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = w_yf;
    assign o_cos  = w_xf;
endmodule
`default_nettype wire

// File: src/modulated_notch_biquad_core.sv
`default_nettype none
// Modulated notch biquad core.
// The input channel (i_valid / o_ready) takes one word holding an audio
// sample and its frequency and resonance control values. The output channel
// (o_valid / i_ready) returns one filtered word per input word, in order.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while the
// core is idle; the user must keep to that, the core does not enforce it.
// Indexes past the register list are ignored. Per word the sequencer runs a
// serial divider (one quotient bit per cycle) for the pitch factor (only when
// the pitch control is zero or negative), the phase, alpha and the two
// coefficient reciprocals, a 24-step CORDIC for sine and cosine, and one
// shared signed multiplier (41 by 25 bits at 24-bit samples) for the
// frequency scaling and the six filter products.
// The division chain sets the pace. The core takes one word at a time and is
// not ready again until its result has been handed over, and a stalled
// receiver holds the core with the result steady on o_sample_out.
// Synchronous active-low reset clears the delay line, restores the default
// register values and empties the core.
module modulated_notch_biquad_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int MIN_FREQ_HZ = 20,
    parameter int MAX_FREQ_HZ = 20000,
    parameter int Q_MIN_Q8    = 26,
    parameter int Q_MAX_Q8    = 25600,
    parameter int Q_SCALE_Q8  = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic signed [15:0]            i_freq_cv,
    input  wire logic signed [15:0]            i_reso_cv,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_idx,
    input  wire logic [17:0]                   i_cfg_data
);
    localparam int SB = SAMPLE_BITS;
    // Multiplier operand widths: the feedforward sum needs SB+17 bits and the
    // frequency base 41; the second operand carries a sample, the gain or the
    // 20-bit pitch factor.
    localparam int MA_W = (SB + 17 > 41) ? SB + 17 : 41;
    localparam int MB_W = (SB + 1 > 20) ? SB + 1 : 20;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FAC   = 4'd1;
    localparam logic [3:0] S_FMUL  = 4'd2;
    localparam logic [3:0] S_PHASE = 4'd3;
    localparam logic [3:0] S_COR   = 4'd4;
    localparam logic [3:0] S_ALPHA = 4'd5;
    localparam logic [3:0] S_N0    = 4'd6;
    localparam logic [3:0] S_N1    = 4'd7;
    localparam logic [3:0] S_MAC   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_UPD   = 4'd10;

    // Configuration registers.
    logic signed [15:0] r_gain, r_pitch;
    logic [15:0]        r_fofs, r_qofs;
    logic [17:0]        r_rate;
    logic [1:0]         r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'sd4096; r_fofs <= 16'd1000; r_pitch <= 16'sd0;
            r_qofs <= 16'd256; r_rate <= 18'd48000; r_mode <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mnb_pkg::REG_GAIN:  r_gain  <= i_cfg_data[15:0];
                mnb_pkg::REG_FOFS:  r_fofs  <= i_cfg_data[15:0];
                mnb_pkg::REG_PITCH: r_pitch <= i_cfg_data[15:0];
                mnb_pkg::REG_QOFS:  r_qofs  <= i_cfg_data[15:0];
                mnb_pkg::REG_RATE:  r_rate  <= i_cfg_data;
                mnb_pkg::REG_MODE:  r_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [3:0]                r_state;
    logic                      r_go;
    logic [2:0]                r_k;
    logic signed [SB-1:0]      r_x, r_xd1, r_xd2, r_yd1, r_yd2, r_y;
    logic signed [15:0]        r_fcv, r_rcv;
    logic [47:0]               r_fq;
    logic [47:0]               r_fac;
    logic signed [33:0]        r_sn, r_cs;
    logic [47:0]               r_den;
    logic signed [33:0]        r_n0, r_n1;
    logic signed [SB+40:0]     r_ff, r_acc;

    mnb_pkg::t_div_req w_req;
    logic        w_ddone, w_cdone;
    logic [63:0] w_quot;
    logic signed [33:0] w_sin, w_cos;

    mnb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
                   .o_done(w_ddone), .o_quot(w_quot));
    mnb_cordic u_cor (.i_clk(i_clk), .i_rst_n(i_rst_n),
                      .i_start(r_go && r_state == S_COR),
                      .i_phase(w_quot[31:0]), .o_done(w_cdone),
                      .o_sin(w_sin), .o_cos(w_cos));

    // Frequency base, Q and the clamped values.
    logic signed [40:0] w_base;
    logic [17:0]        w_rate;
    logic signed [17:0] w_q;
    logic [15:0]        w_qc;
    logic [47:0]        w_fqc;
    logic [16:0]        w_pd;
    logic [47:0]        w_abs_c;

    always_comb begin
        if (r_mode[0] && r_fcv > 16'sd0)
            w_base = 41'(r_fcv) * 41'(MAX_FREQ_HZ)
                   + (41'($signed({1'b0, r_fofs})) - 41'(MIN_FREQ_HZ)) * 41'sd32768;
        else
            w_base = 41'($signed({1'b0, r_fofs})) * 41'sd32768;
        w_rate = (r_rate == 18'd0) ? 18'd1 : r_rate;
        w_q = 18'($signed({1'b0, r_qofs})) + (r_mode[1] ? 18'(r_rcv) : 18'sd0);
        if (w_q < 18'(Q_MIN_Q8)) w_q = 18'(Q_MIN_Q8);
        if (w_q > 18'(Q_MAX_Q8)) w_q = 18'(Q_MAX_Q8);
        w_qc = w_q[15:0];
        w_fqc = r_fq;
        if (w_fqc < (48'(MIN_FREQ_HZ) << 16)) w_fqc = 48'(MIN_FREQ_HZ) << 16;
        if (w_fqc > (48'(MAX_FREQ_HZ) << 16)) w_fqc = 48'(MAX_FREQ_HZ) << 16;
        w_pd = 17'sd8192 - 17'(r_pitch);
        w_abs_c = 48'(r_cs[33] ? -r_cs : r_cs);
    end

    // Shared multiplier: one product per cycle, operands chosen by state and r_k.
    logic signed [MA_W-1:0]      w_ma;
    logic signed [MB_W-1:0]      w_mb;
    logic signed [MA_W+MB_W-1:0] w_prod;
    logic signed [SB+40:0]       w_term;

    always_comb begin
        w_ma = '0; w_mb = '0;
        if (r_state == S_FMUL) begin
            w_ma = MA_W'(w_base); w_mb = MB_W'($signed({1'b0, r_fac[18:0]}));
        end else begin
            case (r_k)
                3'd0: begin w_ma = MA_W'(r_n0); w_mb = MB_W'(r_x); end
                3'd1: begin w_ma = MA_W'(r_n1); w_mb = MB_W'(r_xd1); end
                3'd2: begin w_ma = MA_W'(r_n0); w_mb = MB_W'(r_xd2); end
                3'd3: begin w_ma = MA_W'(r_ff); w_mb = MB_W'(r_gain); end
                3'd4: begin w_ma = MA_W'(r_n1); w_mb = MB_W'(r_yd1); end
                default: begin
                    w_ma = MA_W'(2 * r_n0 - mnb_pkg::ONE_Q30); w_mb = MB_W'(r_yd2);
                end
            endcase
        end
        w_prod = w_ma * w_mb;
        w_term = (r_k == 3'd3) ? (SB+41)'(w_prod >>> 12) : (SB+41)'(w_prod >>> 16);
    end

    logic signed [SB+40:0] w_yr;
    logic signed [SB-1:0]  w_ysat;
    localparam logic signed [SB+40:0] TOP = (SB+41)'((64'sd1 <<< (SB-1)) - 1);

    always_comb begin
        w_yr = (r_acc + (SB+41)'(8192)) >>> 14;
        if (w_yr > TOP) w_ysat = SB'(TOP);
        else if (w_yr < -TOP - 1) w_ysat = SB'(-TOP - 1);
        else w_ysat = w_yr[SB-1:0];
    end

    always_comb begin
        w_req.start = r_go;
        w_req.num = '0; w_req.den = 48'd1;
        unique case (r_state)
            S_FAC: begin
                w_req.num = 64'd536870912 + 64'(w_pd >> 1); w_req.den = 48'(w_pd);
            end
            S_PHASE: begin w_req.num = 64'(w_fqc) << 16; w_req.den = 48'(w_rate); end
            S_ALPHA: begin
                w_req.num = r_sn[33] || r_sn == 0 ? 64'd0 : 64'(r_sn) << 16;
                w_req.den = 48'(Q_SCALE_Q8) * 48'(w_qc);
            end
            S_N0: begin
                w_req.num = (64'd1 << 60) + 64'(r_den >> 1); w_req.den = r_den;
            end
            S_N1: begin
                w_req.num = (64'(w_abs_c) << 31) + 64'(r_den >> 1);
                w_req.den = r_den;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_go <= 1'b0; r_k <= '0;
            r_xd1 <= '0; r_xd2 <= '0; r_yd1 <= '0; r_yd2 <= '0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_x <= i_sample_in; r_fcv <= i_freq_cv; r_rcv <= i_reso_cv;
                    if (r_pitch > 16'sd0) begin
                        r_fac <= 48'd65536 + 48'(r_pitch) * 48'd8;
                        r_state <= S_FMUL;
                    end else begin
                        r_state <= S_FAC; r_go <= 1'b1;
                    end
                end
                S_FAC: if (w_ddone) begin
                    r_fac <= w_quot[47:0]; r_state <= S_FMUL;
                end
                S_FMUL: begin
                    r_fq <= (w_base <= 0) ? 48'd0 : 48'(w_prod >>> 15);
                    r_state <= S_PHASE; r_go <= 1'b1;
                end
                S_PHASE: if (w_ddone) begin
                    r_state <= S_COR; r_go <= 1'b1;
                end
                S_COR: if (w_cdone) begin
                    r_sn <= w_sin; r_cs <= w_cos; r_state <= S_ALPHA; r_go <= 1'b1;
                end
                S_ALPHA: if (w_ddone) begin
                    r_den <= 48'd1073741824 + w_quot[47:0];
                    r_state <= S_N0; r_go <= 1'b1;
                end
                S_N0: if (w_ddone) begin
                    r_n0 <= 34'(w_quot); r_state <= S_N1; r_go <= 1'b1;
                end
                S_N1: if (w_ddone) begin
                    r_n1 <= (r_cs > 0) ? -34'(w_quot) : 34'(w_quot);
                    r_state <= S_MAC; r_k <= '0; r_ff <= '0;
                end
                S_MAC: begin
                    r_k <= r_k + 3'd1;
                    if (r_k < 3'd3) r_ff <= r_ff + w_term;
                    else if (r_k == 3'd3) r_acc <= w_term;
                    else r_acc <= r_acc - w_term;
                    if (r_k == 3'd5) r_state <= S_UPD;
                end
                S_UPD: begin
                    r_y <= w_ysat;
                    r_xd2 <= r_xd1; r_xd1 <= r_x;
                    r_yd2 <= r_yd1; r_yd1 <= w_ysat;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_sample_out = r_y;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("accepted two words");
endmodule
`default_nettype wire

// File: sim/modulated_notch_biquad_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
// Testbench for the modulated notch biquad core.
// A directed table is followed by random words. Every accepted input word is
// run through a bit-true predictor of the filter, and every accepted output
// word is compared with the oldest prediction waiting.
module modulated_notch_biquad_core_tb;
    localparam int SB = 24;
    localparam int MINF = 20;
    localparam int MAXF = 20000;
    localparam int QMIN = 26;
    localparam int QMAX = 25600;
    localparam int QSCALE = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    // Extra wait after the last output word, to cover the final drain.
    localparam int DRAIN_CYCLES = 600;

    // One row of the directed table. The expected output is only checked
    // when has_exp is set; every row also goes through the predictor.
    typedef struct {
        logic signed [SB-1:0] sample;
        logic signed [15:0]   fcv;
        logic signed [15:0]   rcv;
        logic                 has_exp;
        logic signed [SB-1:0] exp_out;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [SB-1:0] i_sample_in = '0;
    logic signed [15:0]   i_freq_cv = '0;
    logic signed [15:0]   i_reso_cv = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [SB-1:0] o_sample_out;
    logic                 i_cfg_we = 1'b0;
    logic [2:0]           i_cfg_idx = '0;
    logic [17:0]          i_cfg_data = '0;

    modulated_notch_biquad_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_sample_in(i_sample_in), .i_freq_cv(i_freq_cv), .i_reso_cv(i_reso_cv),
        .o_valid(o_valid), .i_ready(i_ready), .o_sample_out(o_sample_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor copy of the registers and the delay line.
    longint m_gain, m_fofs, m_pitch, m_qofs, m_rate, m_mode;
    longint m_x1, m_x2, m_y1, m_y2;

    logic signed [SB-1:0] filtered_q[$];
    logic                 checked_q[$];
    logic signed [SB-1:0] literal_q[$];
    int  errors = 0;
    int  quiet_cycles = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // CORDIC rotation on a 32-bit turn fraction, giving Q2.30 sine and cosine.
    function automatic void rotate_phase(input logic [31:0] phase,
                                         output longint sn, output longint cs);
        longint z, x, y, t;
        bit flip;
        longint one;
        one = longint'(1) << 30;
        z = phase[31] ? longint'(phase) - (longint'(1) << 32) : longint'(phase);
        x = longint'(mnb_pkg::CORDIC_K);
        y = 0;
        flip = 1'b0;
        if (z > one) begin
            z -= longint'(1) << 31;
            flip = 1'b1;
        end else if (z < -one) begin
            z += longint'(1) << 31;
            flip = 1'b1;
        end
        for (int i = 0; i < mnb_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t;
                z -= longint'(mnb_pkg::turn_atan(i[4:0]));
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t;
                z += longint'(mnb_pkg::turn_atan(i[4:0]));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        if (x > one) x = one;
        if (x < -one) x = -one;
        if (y > one) y = one;
        if (y < -one) y = -one;
        sn = y;
        cs = x;
    endfunction

    // One filter step of the predictor; updates the delay line.
    function automatic logic signed [SB-1:0] notch_step(
            input logic signed [SB-1:0] xin, input logic signed [15:0] fcv,
            input logic signed [15:0] rcv);
        longint x, base, q, sn, cs, n0, n1, a2n, ff, acc, y, top;
        longint unsigned fac, fq, rate, alpha, den, mag, d;
        logic [31:0] phase;
        x = xin;
        top = (longint'(1) << (SB - 1)) - 1;
        if (m_pitch > 0) begin
            fac = 65536 + longint'(m_pitch) * 8;
        end else begin
            d = 8192 - m_pitch;
            fac = ((64'd1 << 29) + d / 2) / d;
        end
        if (m_mode[0] && fcv > 0) base = longint'(fcv) * MAXF + (m_fofs - MINF) * 32768;
        else base = m_fofs * 32768;
        fq = (base <= 0) ? 64'd0 : ((longint'(base) * fac) >> 15);
        if (fq < (64'(MINF) << 16)) fq = 64'(MINF) << 16;
        if (fq > (64'(MAXF) << 16)) fq = 64'(MAXF) << 16;
        rate = (m_rate > 0) ? m_rate : 1;
        phase = 32'((fq << 16) / rate);
        rotate_phase(phase, sn, cs);
        q = m_qofs + (m_mode[1] ? longint'(rcv) : 0);
        if (q < QMIN) q = QMIN;
        if (q > QMAX) q = QMAX;
        alpha = (sn <= 0) ? 64'd0 : ((64'(sn) << 16) / (64'(QSCALE) * 64'(q)));
        den = (64'd1 << 30) + alpha;
        n0 = ((64'd1 << 60) + den / 2) / den;
        mag = (((64'(cs < 0 ? -cs : cs)) << 31) + den / 2) / den;
        n1 = (cs > 0) ? -longint'(mag) : longint'(mag);
        a2n = 2 * n0 - (longint'(1) << 30);
        ff = floor_shift(n0 * x, 16) + floor_shift(n1 * m_x1, 16)
           + floor_shift(n0 * m_x2, 16);
        acc = floor_shift(ff * m_gain, 12);
        acc -= floor_shift(n1 * m_y1, 16) + floor_shift(a2n * m_y2, 16);
        y = floor_shift(acc + 8192, 14);
        if (y > top) y = top;
        if (y < -top - 1) y = -top - 1;
        m_x2 = m_x1; m_x1 = x; m_y2 = m_y1; m_y1 = y;
        return SB'(y);
    endfunction

    // Output side: random stalls and comparison against predictions.
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if ($urandom_range(0, 3) == 0) gap = 0;
                else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 200);
                else gap = $urandom_range(0, 4);
                if (gap == 0 || ($urandom_range(0, 1) == 0)) i_ready <= 1'b1;
                else begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d",
                         $time, o_sample_out);
                errors++;
            end else begin
                logic signed [SB-1:0] want, lit;
                logic chk;
                want = filtered_q.pop_front();
                chk = checked_q.pop_front();
                lit = literal_q.pop_front();
                if (o_sample_out !== want) begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, want, o_sample_out);
                    errors++;
                end else if (chk && o_sample_out !== lit) begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, lit, o_sample_out);
                    errors++;
                end
            end
        end
    end

    // The watchdog only counts cycles in which no word moves either way.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("modulated_notch_biquad_core_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            mnb_pkg::REG_GAIN:  m_gain  = longint'($signed(val[15:0]));
            mnb_pkg::REG_FOFS:  m_fofs  = val[15:0];
            mnb_pkg::REG_PITCH: m_pitch = longint'($signed(val[15:0]));
            mnb_pkg::REG_QOFS:  m_qofs  = val[15:0];
            mnb_pkg::REG_RATE:  m_rate  = val;
            mnb_pkg::REG_MODE:  m_mode  = val[1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one word after an optional random gap; the prediction is queued
    // at acceptance.
    task automatic send_word(input logic signed [SB-1:0] s, input logic signed [15:0] f,
                             input logic signed [15:0] r, input logic chk,
                             input logic signed [SB-1:0] lit);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 :
              (($urandom_range(0, 15) == 0) ? $urandom_range(50, 600)
                                           : $urandom_range(0, 5));
        repeat (gap) @(posedge i_clk);
        i_valid <= 1'b1;
        i_sample_in <= s;
        i_freq_cv <= f;
        i_reso_cv <= r;
        do @(posedge i_clk); while (!o_ready);
        filtered_q.push_back(notch_step(s, f, r));
        checked_q.push_back(chk);
        literal_q.push_back(lit);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SB-1){1'b1}}};
            1: return {1'b1, {(SB-1){1'b0}}};
            2: return SB'($signed($urandom_range(0, 2000)) - 1000);
            default: return SB'($urandom);
        endcase
    endfunction

    initial begin
        t_row rows[$];
        longint mx;
        mx = (longint'(1) << (SB - 1)) - 1;
        m_gain = 4096; m_fofs = 1000; m_pitch = 0; m_qofs = 256;
        m_rate = 48000; m_mode = 0;
        m_x1 = 0; m_x2 = 0; m_y1 = 0; m_y2 = 0;

        // After reset a zero input must give zero; the rest are predicted.
        rows.push_back('{SB'(0), 16'sd0, 16'sd0, 1'b1, SB'(0)});
        rows.push_back('{SB'(mx), 16'sd0, 16'sd0, 1'b0, '0});
        rows.push_back('{SB'(-mx - 1), 16'sh7fff, 16'sh7fff, 1'b0, '0});
        rows.push_back('{SB'(-mx - 1), -16'sd32768, -16'sd32768, 1'b0, '0});
        rows.push_back('{SB'(mx), 16'sh7fff, -16'sd32768, 1'b0, '0});
        rows.push_back('{SB'(1), 16'sd1, 16'sd1, 1'b0, '0});
        rows.push_back('{-SB'(1), -16'sd1, -16'sd1, 1'b0, '0});
        rows.push_back('{SB'(0), 16'sd0, 16'sd0, 1'b0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_word(rows[k].sample, rows[k].fcv, rows[k].rcv,
                                    rows[k].has_exp, rows[k].exp_out);
        wait_idle();

        // Extreme settings: both controls on, maximum gain, zero sample rate
        // (treated as one), an index past the register list.
        write_reg(mnb_pkg::REG_MODE, 18'd3);
        write_reg(mnb_pkg::REG_GAIN, 18'h07fff);
        write_reg(mnb_pkg::REG_PITCH, 18'h07fff);
        write_reg(mnb_pkg::REG_RATE, 18'd0);
        write_reg(3'd7, 18'h3ffff);
        for (int k = 0; k < 6; k++)
            send_word(rand_sample(), 16'sh7fff, 16'sh7fff, 1'b0, '0);
        wait_idle();
        write_reg(mnb_pkg::REG_GAIN, 18'h08000);
        write_reg(mnb_pkg::REG_PITCH, 18'h08000);
        write_reg(mnb_pkg::REG_FOFS, 18'h0ffff);
        write_reg(mnb_pkg::REG_QOFS, 18'd0);
        write_reg(mnb_pkg::REG_RATE, 18'h3ffff);
        for (int k = 0; k < 6; k++)
            send_word(rand_sample(), -16'sd32768, 16'sd0, 1'b0, '0);
        wait_idle();
        // Phase past half a turn: high frequency at a low rate.
        write_reg(mnb_pkg::REG_FOFS, 18'd700);
        write_reg(mnb_pkg::REG_QOFS, 18'h0ffff);
        write_reg(mnb_pkg::REG_RATE, 18'd1000);
        write_reg(mnb_pkg::REG_PITCH, 18'd0);
        write_reg(mnb_pkg::REG_GAIN, 18'd4096);
        for (int k = 0; k < 6; k++)
            send_word(rand_sample(), 16'sd0, 16'sd100, 1'b0, '0);
        wait_idle();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(mnb_pkg::REG_GAIN, 18'($urandom));
            write_reg(mnb_pkg::REG_FOFS, ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                         : 18'($urandom_range(20, 20000)));
            write_reg(mnb_pkg::REG_PITCH, 18'($urandom));
            write_reg(mnb_pkg::REG_QOFS, ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                         : 18'($urandom_range(26, 4000)));
            write_reg(mnb_pkg::REG_RATE, ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                         : 18'($urandom_range(8000, 192000)));
            write_reg(mnb_pkg::REG_MODE, 18'($urandom_range(0, 3)));
            for (int k = 0; k < 78; k++)
                send_word(rand_sample(), 16'($urandom), 16'($urandom), 1'b0, '0);
            wait_idle();
        end

        if (errors == 0) begin
            $display("modulated_notch_biquad_core_tb passed");
        end else begin
            $display("modulated_notch_biquad_core_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
